// File: design/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared widths, command and register codes, and the compare result type of
// the fibonacci search sorted table.
// ----------------------------------------------------------------------------
package fss_pkg;

    // payload widths
    localparam int SLOT_W = 10;
    localparam int KEY_W  = 32;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 11;

    // fibonacci terms reach 2584 for a count of 2047
    localparam int FIB_W  = CNT_W + 1;
    // signed offset, from -1 up past the last entry
    localparam int BASE_W = CNT_W + 2;

    // apb port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // register index (paddr bit 2)
    localparam logic REG_ENTRY_COUNT     = 1'b0;
    localparam logic REG_BOUNDS_PRECHECK = 1'b1;

    // key against entry
    typedef struct packed {
        logic key_lt;
        logic key_eq;
        logic key_gt;
    } t_cmp;

endpackage

// File: design/fss_in_if.sv
// ----------------------------------------------------------------------------
// fss_in_if
// Input channel: one beat is a table write or a search key.
// ----------------------------------------------------------------------------
interface fss_in_if;
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic [fss_pkg::SLOT_W-1:0]         slot;
    logic signed [fss_pkg::KEY_W-1:0]   value;

    modport source (output valid, output cmd, output slot, output value, input ready);
    modport sink   (input valid, input cmd, input slot, input value, output ready);
endinterface

// File: design/fss_out_if.sv
// ----------------------------------------------------------------------------
// fss_out_if
// Output channel: one beat is the result of one search.
// ----------------------------------------------------------------------------
interface fss_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [fss_pkg::POS_W-1:0]  position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

// File: design/fss_ram.sv
// ----------------------------------------------------------------------------
// fss_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/fss_cmp.sv
// ----------------------------------------------------------------------------
// fss_cmp
// Shared signed compare unit: search key against one table entry.
// ----------------------------------------------------------------------------
module fss_cmp #(
    parameter int ENTRY_WIDTH = 32
) (
    input  logic signed [fss_pkg::KEY_W-1:0] i_key,
    input  logic [ENTRY_WIDTH-1:0]           i_entry,
    output fss_pkg::t_cmp                    o_res
);
    localparam int CW = (ENTRY_WIDTH > fss_pkg::KEY_W) ? ENTRY_WIDTH : fss_pkg::KEY_W;

    logic signed [CW-1:0] w_key;
    logic signed [CW-1:0] w_entry;

    // both sides sign-extended to a common width
    assign w_key   = CW'(i_key);
    assign w_entry = CW'($signed(i_entry));

    assign o_res.key_lt = (w_key < w_entry);
    assign o_res.key_eq = (w_key == w_entry);
    assign o_res.key_gt = (w_key > w_entry);
endmodule

// File: design/fss_seq.sv
// ----------------------------------------------------------------------------
// fss_seq
// Search sequencer: takes input beats, steers the table RAM and the shared
// compare unit through the bounds check, fibonacci growth and probe loop,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module fss_seq #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 32,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fss_in_if.sink                            i_in,
    fss_out_if.source                         o_out,
    input  logic [fss_pkg::CNT_W-1:0]         i_entry_count,
    input  logic                              i_bounds_precheck,
    input  fss_pkg::t_cmp                     i_cmp,
    output logic signed [fss_pkg::KEY_W-1:0]  o_key,
    output logic                              o_we,
    output logic [AW-1:0]                     o_waddr,
    output logic [ENTRY_WIDTH-1:0]            o_wdata,
    output logic [AW-1:0]                     o_raddr
);
    localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

    localparam int CNT_W  = fss_pkg::CNT_W;
    localparam int FIB_W  = fss_pkg::FIB_W;
    localparam int BASE_W = fss_pkg::BASE_W;
    localparam int POS_W  = fss_pkg::POS_W;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_FIRST_CMP = 8'b0000_0010,
        S_LAST_CMP  = 8'b0000_0100,
        S_GROW      = 8'b0000_1000,
        S_PROBE     = 8'b0001_0000,
        S_PROBE_CMP = 8'b0010_0000,
        S_FINAL_CMP = 8'b0100_0000,
        S_RESP      = 8'b1000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic signed [31:0]         r_key, n_key;
    logic [CNT_W-1:0]           r_n, n_n;
    logic [FIB_W-1:0]           r_fm, n_fm;
    logic [FIB_W-1:0]           r_f1, n_f1;
    logic [FIB_W-1:0]           r_f2, n_f2;
    logic signed [BASE_W-1:0]   r_base, n_base;
    logic [CNT_W-1:0]           r_idx, n_idx;
    logic                       r_first_below, n_first_below;
    logic                       r_first_eq, n_first_eq;
    logic                       r_res_found, n_res_found;
    logic [POS_W-1:0]           r_res_pos, n_res_pos;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_found, n_out_found;
    logic [POS_W-1:0]           r_out_pos, n_out_pos;

    logic                       accept;
    logic [CNT_W-1:0]           eff_n;
    logic [CNT_W-1:0]           n_last;
    logic signed [BASE_W-1:0]   probe_sum;
    logic [CNT_W-1:0]           probe_idx;
    logic signed [BASE_W-1:0]   base_p1;
    logic                       final_ok;
    logic [FIB_W-1:0]           fib_sum;
    logic                       out_free;
    logic [CNT_W-1:0]           rd_idx;

    // handshake and helpers
    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    // count limited to the table depth
    assign eff_n  = (17'(i_entry_count) > DEPTH_V) ? DEPTH_V[CNT_W-1:0] : i_entry_count;
    assign n_last = r_n - CNT_W'(1);

    // probe index, clamped to the valid entries
    assign probe_sum = r_base + $signed(BASE_W'(r_f2));
    always_comb begin
        if (probe_sum < 0) begin
            probe_idx = '0;
        end else if (probe_sum > $signed(BASE_W'(n_last))) begin
            probe_idx = n_last;
        end else begin
            probe_idx = probe_sum[CNT_W-1:0];
        end
    end

    // entry after the offset for the closing check
    assign base_p1  = r_base + BASE_W'(1);
    assign final_ok = (r_f1 != '0) && (base_p1 < $signed(BASE_W'(r_n)));
    assign fib_sum  = r_f1 + r_fm;

    // table write port
    assign o_we    = accept && (i_in.cmd == fss_pkg::CMD_WRITE)
                     && ({7'b0, i_in.slot} < DEPTH_V);
    assign o_waddr = AW'(i_in.slot);
    assign o_wdata = ENTRY_WIDTH'(i_in.value);
    assign o_raddr = AW'(rd_idx);
    assign o_key   = r_key;

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_key         = r_key;
        n_n           = r_n;
        n_fm          = r_fm;
        n_f1          = r_f1;
        n_f2          = r_f2;
        n_base        = r_base;
        n_idx         = r_idx;
        n_first_below = r_first_below;
        n_first_eq    = r_first_eq;
        n_res_found   = r_res_found;
        n_res_pos     = r_res_pos;
        rd_idx        = '0;
        case (r_state)
            S_IDLE: begin
                // address 0 is read here for the first-entry check
                if (accept && (i_in.cmd == fss_pkg::CMD_SEARCH)) begin
                    n_key       = i_in.value;
                    n_n         = eff_n;
                    n_f2        = '0;
                    n_f1        = FIB_W'(1);
                    n_fm        = FIB_W'(1);
                    n_base      = -BASE_W'(1);
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    if (eff_n == '0) begin
                        n_state = S_RESP;
                    end else if (i_bounds_precheck) begin
                        n_state = S_FIRST_CMP;
                    end else begin
                        n_state = S_GROW;
                    end
                end
            end
            S_FIRST_CMP: begin
                n_first_below = i_cmp.key_lt;
                n_first_eq    = i_cmp.key_eq;
                rd_idx        = n_last;
                n_state       = S_LAST_CMP;
            end
            S_LAST_CMP: begin
                if (r_first_below || i_cmp.key_gt) begin
                    n_state = S_RESP;
                end else if (r_first_eq) begin
                    n_res_found = 1'b1;
                    n_res_pos   = '0;
                    n_state     = S_RESP;
                end else if (i_cmp.key_eq) begin
                    n_res_found = 1'b1;
                    n_res_pos   = n_last[POS_W-1:0];
                    n_state     = S_RESP;
                end else begin
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                // step up to the smallest fibonacci number not below the count
                if ({1'b0, r_n} > r_fm) begin
                    n_f2 = r_f1;
                    n_f1 = r_fm;
                    n_fm = fib_sum;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_fm > FIB_W'(1)) begin
                    rd_idx  = probe_idx;
                    n_idx   = probe_idx;
                    n_state = S_PROBE_CMP;
                end else if (final_ok) begin
                    rd_idx  = base_p1[CNT_W-1:0];
                    n_idx   = base_p1[CNT_W-1:0];
                    n_state = S_FINAL_CMP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_PROBE_CMP: begin
                if (i_cmp.key_gt) begin
                    // entry below key: move the offset up
                    n_fm    = r_f1;
                    n_f1    = r_f2;
                    n_f2    = r_f1 - r_f2;
                    n_base  = $signed(BASE_W'(r_idx));
                    n_state = S_PROBE;
                end else if (i_cmp.key_lt) begin
                    // entry above key: shrink the range
                    n_fm    = r_f2;
                    n_f1    = r_f1 - r_f2;
                    n_f2    = r_f2 - (r_f1 - r_f2);
                    n_state = S_PROBE;
                end else begin
                    n_res_found = 1'b1;
                    n_res_pos   = r_idx[POS_W-1:0];
                    n_state     = S_RESP;
                end
            end
            S_FINAL_CMP: begin
                if (i_cmp.key_eq) begin
                    n_res_found = 1'b1;
                    n_res_pos   = r_idx[POS_W-1:0];
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == S_RESP) && out_free) begin
            n_out_valid = 1'b1;
            n_out_found = r_res_found;
            n_out_pos   = r_res_pos;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_out_found;
    assign o_out.position = r_out_pos;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_n           <= n_n;
        r_fm          <= n_fm;
        r_f1          <= n_f1;
        r_f2          <= n_f2;
        r_base        <= n_base;
        r_idx         <= n_idx;
        r_first_below <= n_first_below;
        r_first_eq    <= n_first_eq;
        r_res_found   <= n_res_found;
        r_res_pos     <= n_res_pos;
        r_out_found   <= n_out_found;
        r_out_pos     <= n_out_pos;
    end
endmodule

// File: design/fibonacci_search_sorted_table.sv
// Write beat: taken while idle, no result; the sequencer stays idle, so ready stays high.
// Search beat: optional bounds check on the first and last entry, fibonacci growth
// steps, then the probe loop (read, then compare) and the closing check; the result
// is then loaded into the output register. The next beat is taken once the sequencer
// is idle again, which waits while the output register holds an untaken result.
// Synchronous active-low reset clears the sequencer, output valid and APB registers.
// ----------------------------------------------------------------------------
// fibonacci_search_sorted_table
// Sorted table of signed entries with a fibonacci search, an APB register
// port for the entry count and the bounds check enable.
// ----------------------------------------------------------------------------
module fibonacci_search_sorted_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fss_in_if.sink                        i_in,
    fss_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fss_pkg::APB_AW-1:0]    paddr,
    input  logic [fss_pkg::APB_DW-1:0]    pwdata,
    output logic [fss_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = fss_pkg::CNT_W;

    logic [CNT_W-1:0]                  r_entry_count, n_entry_count;
    logic                              r_bounds_precheck, n_bounds_precheck;
    logic                              apb_wr;
    logic                              reg_idx;
    logic signed [fss_pkg::KEY_W-1:0]  key;
    fss_pkg::t_cmp                     cmp_res;
    logic                              we;
    logic [AW-1:0]                     waddr;
    logic [ENTRY_WIDTH-1:0]            wdata;
    logic [AW-1:0]                     raddr;
    logic [ENTRY_WIDTH-1:0]            rdata;

    // apb register port
    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_comb begin
        n_entry_count     = r_entry_count;
        n_bounds_precheck = r_bounds_precheck;
        prdata            = '0;
        case (reg_idx)
            fss_pkg::REG_ENTRY_COUNT: begin
                prdata = fss_pkg::APB_DW'(r_entry_count);
                if (apb_wr) begin
                    n_entry_count = pwdata[CNT_W-1:0];
                end
            end
            fss_pkg::REG_BOUNDS_PRECHECK: begin
                prdata = fss_pkg::APB_DW'(r_bounds_precheck);
                if (apb_wr) begin
                    n_bounds_precheck = pwdata[0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count     <= '0;
            r_bounds_precheck <= 1'b0;
        end else begin
            r_entry_count     <= n_entry_count;
            r_bounds_precheck <= n_bounds_precheck;
        end
    end

    // table storage
    fss_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // shared comparator
    fss_cmp #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cmp (
        .i_key   (key),
        .i_entry (rdata),
        .o_res   (cmp_res)
    );

    // search sequencer
    fss_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (i_in),
        .o_out             (o_out),
        .i_entry_count     (r_entry_count),
        .i_bounds_precheck (r_bounds_precheck),
        .i_cmp             (cmp_res),
        .o_key             (key),
        .o_we              (we),
        .o_waddr           (waddr),
        .o_wdata           (wdata),
        .o_raddr           (raddr)
    );
endmodule
